// File: rtl/core/rlbd_pkg.sv
// Shared constants and widths for the resistor-ladder button decoder.
// No dependencies.
`default_nettype none
package rlbd_pkg;
    localparam logic OP_DECODE = 1'b0;
    localparam logic OP_LOAD   = 1'b1;
    localparam logic KIND_SINGLE = 1'b0;
    localparam logic KIND_MULTI  = 1'b1;
    localparam logic [1:0] REG_COUNT  = 2'd0;
    localparam logic [1:0] REG_SUPPLY = 2'd1;
    localparam logic [1:0] REG_SERIES = 2'd2;
    localparam logic [15:0] SUPPLY_RESET = 16'd3300;
    localparam int NUM_W = 49;
    localparam int DEN_W = 18;
    localparam int QUO_W = 49;
endpackage
`default_nettype wire

// File: rtl/core/rlbd_divider.sv
// Restoring bit-serial divider: one quotient bit per cycle.
// Depends on rlbd_pkg.
`default_nettype none
module rlbd_divider
    import rlbd_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  done,
    output logic [QUO_W-1:0]      quo
);
    logic [NUM_W-1:0] q_reg;
    logic [DEN_W:0]   rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [5:0]       cnt_reg;
    logic             busy_reg;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;

    assign shifted = {rem_reg[DEN_W-1:0], q_reg[NUM_W-1]};
    assign diff    = shifted - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'(NUM_W);
                q_reg    <= num;
                rem_reg  <= '0;
                den_reg  <= den;
            end else if (busy_reg) begin
                if (!diff[DEN_W]) begin
                    rem_reg <= diff;
                    q_reg   <= {q_reg[NUM_W-2:0], 1'b1};
                end else begin
                    rem_reg <= shifted;
                    q_reg   <= {q_reg[NUM_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end
    assign quo = q_reg;
endmodule
`default_nettype wire

// File: rtl/core/rlbd_multiplier.sv
// Shift-add multiplier: 17-bit sample times 32-bit resistance, one bit per cycle.
// Depends on rlbd_pkg.
`default_nettype none
module rlbd_multiplier
    import rlbd_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [16:0]      a,
    input  wire logic [31:0]      b,
    output logic                  done,
    output logic [NUM_W-1:0]      prod
);
    logic [16:0]      a_reg;
    logic [NUM_W-1:0] b_reg;
    logic [NUM_W-1:0] acc_reg;
    logic [4:0]       cnt_reg;
    logic             busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd17;
                a_reg    <= a;
                b_reg    <= NUM_W'(b);
                acc_reg  <= '0;
            end else if (busy_reg) begin
                if (a_reg[0]) acc_reg <= acc_reg + b_reg;
                a_reg   <= a_reg >> 1;
                b_reg   <= b_reg << 1;
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1) begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end
    assign prod = acc_reg;
endmodule
`default_nettype wire

// File: rtl/core/resistor_ladder_button_decoder.sv
// Top level: table, sequencer, window scan and resistance walk.
// Depends on rlbd_pkg, rlbd_multiplier, rlbd_divider.
//
//  channel | prefix | direction | carries
//  input   | s_     | in        | op, sample, table entry
//  result  | m_     | out       | press_kind, button_value
//  config  | cfg_   | in        | button_count, supply, series R
//
// Load: writes one table entry and is ready again at once. Decode: window steps over
// the n buttons in use, a multiply, a divide (49 quotient bits), walk steps over the
// n buttons and an output step. A window hit skips the multiply, divide and walk.
// Reset is synchronous, active low.
// A result sits in the output register; the next request is taken while it waits.
`default_nettype none
module resistor_ladder_button_decoder
    import rlbd_pkg::*;
#(
    parameter int BUTTONS = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_op,
    input  wire logic [16:0] s_sample_sum,
    input  wire logic [3:0]  s_entry_index,
    input  wire logic [15:0] s_entry_voltage,
    input  wire logic [15:0] s_entry_tolerance,
    input  wire logic [31:0] s_entry_resistance,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_press_kind,
    output logic [7:0]       m_button_value
);
    localparam int IW = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
    localparam logic [2:0] ST_IDLE = 3'd0, ST_WIN = 3'd1, ST_MUL = 3'd2,
                           ST_DIV = 3'd3, ST_WALK = 3'd4, ST_OUT = 3'd5;

    logic [15:0] volt_mem [BUTTONS];
    logic [15:0] tol_mem  [BUTTONS];
    logic [31:0] res_mem  [BUTTONS];

    logic [3:0]  count_reg;
    logic [15:0] supply_reg;
    logic [31:0] series_reg;

    logic [2:0]  state_reg;
    logic [16:0] sum_reg;
    logic [3:0]  k_reg;
    logic [3:0]  n_reg;
    logic [7:0]  mask_reg;
    logic        kind_reg;
    logic signed [50:0] rem_reg;
    logic        mul_start, div_start, mul_done, div_done;
    logic [NUM_W-1:0] prod;
    logic [QUO_W-1:0] quo;
    logic [DEN_W-1:0] den;

    logic [15:0] e_v, e_t;
    logic [31:0] e_r;
    logic [16:0] lo, hi;
    logic [15:0] vavg;
    logic        win_hit, walk_hit;

    assign e_v = volt_mem[k_reg[IW-1:0]];
    assign e_t = tol_mem[k_reg[IW-1:0]];
    assign e_r = res_mem[k_reg[IW-1:0]];
    assign vavg = sum_reg[16:1];
    assign lo = {1'b0, e_v} - {1'b0, e_t};
    assign hi = {1'b0, e_v} + {1'b0, e_t};
    assign win_hit = (e_t <= e_v) && ({1'b0, vavg} >= lo) && ({1'b0, vavg} <= hi);
    assign walk_hit = (e_t <= e_r[15:0] || e_r[31:16] != 16'd0) &&
                      (rem_reg >= $signed({19'd0, e_r - {16'd0, e_t}}));
    assign den = {1'b0, supply_reg, 1'b0} - {1'b0, sum_reg};

    rlbd_multiplier u_mul (.aclk, .aresetn, .start(mul_start), .a(sum_reg),
                           .b(series_reg), .done(mul_done), .prod);
    rlbd_divider u_div (.aclk, .aresetn, .start(div_start), .num(prod), .den,
                        .done(div_done), .quo);

    assign s_ready = (state_reg == ST_IDLE);
    assign mul_start = (state_reg == ST_WIN) && (k_reg >= n_reg) &&
                       ({1'b0, sum_reg} < {1'b0, supply_reg, 1'b0});
    assign div_start = (state_reg == ST_MUL) && mul_done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            supply_reg <= SUPPLY_RESET;
            series_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_COUNT:  count_reg  <= cfg_data[3:0];
                REG_SUPPLY: supply_reg <= cfg_data[15:0];
                REG_SERIES: series_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready && s_op == OP_LOAD && s_entry_index >= 4'd1 &&
            {28'd0, s_entry_index} <= 32'(BUTTONS)) begin
            volt_mem[IW'(s_entry_index - 4'd1)] <= s_entry_voltage;
            tol_mem[IW'(s_entry_index - 4'd1)]  <= s_entry_tolerance;
            res_mem[IW'(s_entry_index - 4'd1)]  <= s_entry_resistance;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            m_valid   <= 1'b0;
        end else begin
            if (state_reg == ST_OUT && (!m_valid || m_ready)) begin
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: if (s_valid && s_op == OP_DECODE) begin
                    sum_reg   <= s_sample_sum;
                    k_reg     <= '0;
                    n_reg     <= ({28'd0, count_reg} > 32'(BUTTONS)) ? 4'(BUTTONS) : count_reg;
                    state_reg <= ST_WIN;
                end
                ST_WIN: begin
                    if (k_reg >= n_reg) begin
                        state_reg <= mul_start ? ST_MUL : ST_IDLE;
                    end else if (win_hit) begin
                        mask_reg  <= 8'(k_reg + 4'd1);
                        kind_reg  <= KIND_SINGLE;
                        state_reg <= ST_OUT;
                    end else k_reg <= k_reg + 4'd1;
                end
                ST_MUL: if (mul_done) state_reg <= ST_DIV;
                ST_DIV: if (div_done) begin
                    rem_reg   <= $signed({2'd0, quo});
                    k_reg     <= '0;
                    mask_reg  <= '0;
                    state_reg <= ST_WALK;
                end
                ST_WALK: begin
                    if (k_reg >= n_reg) begin
                        kind_reg  <= KIND_MULTI;
                        state_reg <= (mask_reg != 8'd0) ? ST_OUT : ST_IDLE;
                    end else begin
                        if (walk_hit) begin
                            mask_reg[k_reg[2:0]] <= 1'b1;
                            rem_reg <= rem_reg - $signed({19'd0, e_r});
                        end
                        k_reg <= k_reg + 4'd1;
                    end
                end
                ST_OUT: if (!m_valid || m_ready) begin
                    m_press_kind   <= kind_reg;
                    m_button_value <= mask_reg;
                    state_reg      <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/rlbd_checker.sv
// Port-level checks for the button decoder, bound to the top level.
// Depends on rlbd_pkg and resistor_ladder_button_decoder.
`default_nettype none
module rlbd_checker
    import rlbd_pkg::*;
(
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic       s_op,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic       m_press_kind,
    input wire logic [7:0] m_button_value
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_button_value) && $stable(m_press_kind))
        else $error("result dropped while stalled");
    a_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_button_value != 8'd0) else $error("zero result");
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_press_kind == KIND_SINGLE |-> m_button_value <= 8'd8)
        else $error("bad single index");
    // a decode occupies the sequencer; a load does not
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_op == OP_DECODE |=> !s_ready)
        else $error("ready after decode accept");
endmodule

bind resistor_ladder_button_decoder rlbd_checker u_chk (.*);
`default_nettype wire
